/* hw/rtl/bpa_pkg.sv */
package bpa_pkg;

   localparam int MAX_LEVEL = 10;
   localparam int REGIONS   = 4;
   localparam int REG_W     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int NODE_W    = REG_W + MAX_LEVEL;
   localparam int CODE_W    = NODE_W + 1;
   localparam int LVL_W     = 4;
   localparam int IDX_W     = 12;

   localparam logic [CODE_W-1:0] NIL = {CODE_W{1'b1}};

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic              wr_en;
      logic [NODE_W-1:0] wr_addr;
      logic              wr_data;
      logic              rd_en;
      logic [NODE_W-1:0] rd_addr;
   } pair_port_type;

   typedef struct packed {
      logic              wr_en;
      logic [NODE_W-1:0] wr_addr;
      logic [CODE_W-1:0] wr_data;
      logic              rd_en;
      logic [NODE_W-1:0] rd_addr;
   } link_port_type;

   typedef struct packed {
      logic [IDX_W-1:0] alloc_index;
      logic             out_of_memory;
   } result_type;

   function automatic logic is_node(logic [CODE_W-1:0] code);
      return !code[CODE_W-1];
   endfunction

   function automatic logic [CODE_W-1:0] head_ref(logic [LVL_W-1:0] lv);
      return {1'b1, NODE_W'(lv)};
   endfunction

   // start address of a block in smallest-block units
   function automatic logic [NODE_W-1:0] node_of(logic [REG_W-1:0] region,
                                                 logic [LVL_W-1:0] lv,
                                                 logic [MAX_LEVEL-1:0] loc);
      logic [MAX_LEVEL-1:0] sh;
      sh = loc << (LVL_W'(MAX_LEVEL) - lv);
      return {region, sh};
   endfunction

   function automatic logic [NODE_W-1:0] pair_of(logic [REG_W-1:0] region,
                                                 logic [LVL_W-1:0] lv,
                                                 logic [MAX_LEVEL-1:0] loc);
      logic [MAX_LEVEL:0] t;
      t = ({{MAX_LEVEL{1'b0}}, 1'b1} << lv) + {1'b0, loc};
      return {region, t[MAX_LEVEL:1]};
   endfunction

endpackage

/* hw/rtl/bpa_ram.sv */
module bpa_ram #(
   parameter int WIDTH  = 1,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:(1<<ADDR_W)-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bpa_core.sv */
module bpa_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [bpa_pkg::LVL_W-1:0]     req_size_level,
   input  logic [bpa_pkg::IDX_W-1:0]     req_block_index,
   output logic                          res_valid,
   input  logic                          res_ready,
   output bpa_pkg::result_type           res,
   output bpa_pkg::pair_port_type        pair_port,
   output bpa_pkg::link_port_type        next_port,
   output bpa_pkg::link_port_type        prev_port,
   input  logic                          pair_rdata,
   input  logic [bpa_pkg::CODE_W-1:0]    next_rdata,
   input  logic [bpa_pkg::CODE_W-1:0]    prev_rdata
);

   localparam int ML     = bpa_pkg::MAX_LEVEL;
   localparam int NODE_W = bpa_pkg::NODE_W;
   localparam int CODE_W = bpa_pkg::CODE_W;
   localparam int LVL_W  = bpa_pkg::LVL_W;
   localparam int REG_W  = bpa_pkg::REG_W;
   localparam int IDX_W  = bpa_pkg::IDX_W;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_A_POP = 4'd2;
   localparam logic [3:0] ST_A_SPL = 4'd3;
   localparam logic [3:0] ST_F_RD  = 4'd4;
   localparam logic [3:0] ST_F_CHK = 4'd5;
   localparam logic [3:0] ST_PUSH1 = 4'd6;
   localparam logic [3:0] ST_PUSH2 = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in;
   logic              func_ff, func_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [LVL_W-1:0]  lv_ff, lv_in;
   logic [ML-1:0]     loc_ff, loc_in;
   logic [REG_W-1:0]  region_ff, region_in;
   logic [NODE_W-1:0] n_ff, n_in;
   logic [CODE_W-1:0] h_ff, h_in;
   logic              oom_ff, oom_in;
   logic [CODE_W-1:0] heads_ff [0:ML];

   logic              head_we;
   logic [LVL_W-1:0]  head_idx;
   logic [CODE_W-1:0] head_wd;

   logic              found;
   logic [LVL_W-1:0]  b_sel;
   logic [IDX_W-1:0]  region_full;
   logic [IDX_W-1:0]  loc_mask;
   logic [LVL_W-1:0]  nlv;
   logic [ML-1:0]     nloc;
   logic [ML-1:0]     pop_loc;
   logic [CODE_W-1:0] x_code;
   logic [IDX_W-1:0]  idx_out;

   // deepest non-empty list at or above the requested level
   always_comb begin
      found = 1'b0;
      b_sel = '0;
      for (int i = 0; i <= ML; i++) begin
         if (LVL_W'(i) <= req_size_level && bpa_pkg::is_node(heads_ff[i])) begin
            found = 1'b1;
            b_sel = LVL_W'(i);
         end
      end
      if (req_size_level > LVL_W'(ML)) begin
         found = 1'b0;
      end
   end

   assign region_full = req_block_index >> req_size_level;
   assign loc_mask    = (IDX_W'(1) << req_size_level) - IDX_W'(1);
   assign nlv         = lv_ff + LVL_W'(1);
   assign nloc        = loc_ff << 1;
   assign pop_loc     = n_ff[ML-1:0] >> (LVL_W'(ML) - lv_ff);
   assign x_code      = bpa_pkg::is_node(next_rdata) ? next_rdata : bpa_pkg::NIL;
   assign idx_out     = (IDX_W'(region_ff) << lvl_ff) | IDX_W'(loc_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res.out_of_memory = oom_ff;
   assign res.alloc_index   = (func_ff == bpa_pkg::FUNC_ALLOC && !oom_ff) ? idx_out : '0;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      func_in   = func_ff;
      lvl_in    = lvl_ff;
      lv_in     = lv_ff;
      loc_in    = loc_ff;
      region_in = region_ff;
      n_in      = n_ff;
      h_in      = h_ff;
      oom_in    = oom_ff;
      head_we   = 1'b0;
      head_idx  = lv_ff;
      head_wd   = bpa_pkg::NIL;
      pair_port = '0;
      next_port = '0;
      prev_port = '0;

      unique case (state_ff)
         ST_CLR: begin
            pair_port.wr_en   = 1'b1;
            pair_port.wr_addr = cnt_ff;
            pair_port.wr_data = 1'b1;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == {NODE_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               lvl_in  = req_size_level;
               oom_in  = 1'b0;
               if (req_func == bpa_pkg::FUNC_ALLOC) begin
                  if (!found) begin
                     oom_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     lv_in = b_sel;
                     n_in  = heads_ff[b_sel][NODE_W-1:0];
                     next_port.rd_en   = 1'b1;
                     next_port.rd_addr = heads_ff[b_sel][NODE_W-1:0];
                     state_in = ST_A_POP;
                  end
               end else begin
                  region_in = region_full[REG_W-1:0];
                  loc_in    = ML'(req_block_index & loc_mask);
                  lv_in     = req_size_level;
                  if (req_size_level > LVL_W'(ML) ||
                      region_full >= IDX_W'(bpa_pkg::REGIONS)) begin
                     state_in = ST_DONE;
                  end else if (req_size_level == '0) begin
                     n_in     = bpa_pkg::node_of(region_full[REG_W-1:0], '0, '0);
                     state_in = ST_PUSH1;
                  end else begin
                     state_in = ST_F_RD;
                  end
               end
            end
         end
         ST_A_POP: begin
            head_we  = 1'b1;
            head_idx = lv_ff;
            head_wd  = x_code;
            if (bpa_pkg::is_node(x_code)) begin
               prev_port.wr_en   = 1'b1;
               prev_port.wr_addr = x_code[NODE_W-1:0];
               prev_port.wr_data = bpa_pkg::head_ref(lv_ff);
            end
            pair_port.wr_en   = 1'b1;
            pair_port.wr_addr = bpa_pkg::pair_of(n_ff[NODE_W-1:ML], lv_ff, pop_loc);
            pair_port.wr_data = 1'b1;
            region_in = n_ff[NODE_W-1:ML];
            loc_in    = pop_loc;
            state_in  = ST_A_SPL;
         end
         ST_A_SPL: begin
            if (lv_ff == lvl_ff) begin
               state_in = ST_DONE;
            end else begin
               pair_port.wr_en   = 1'b1;
               pair_port.wr_addr = bpa_pkg::pair_of(region_ff, nlv, nloc);
               pair_port.wr_data = 1'b0;
               n_in     = bpa_pkg::node_of(region_ff, nlv, nloc | ML'(1));
               lv_in    = nlv;
               loc_in   = nloc;
               state_in = ST_PUSH1;
            end
         end
         ST_F_RD: begin
            pair_port.rd_en   = 1'b1;
            pair_port.rd_addr = bpa_pkg::pair_of(region_ff, lv_ff, loc_ff);
            next_port.rd_en   = 1'b1;
            next_port.rd_addr = bpa_pkg::node_of(region_ff, lv_ff, loc_ff ^ ML'(1));
            prev_port.rd_en   = 1'b1;
            prev_port.rd_addr = next_port.rd_addr;
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            if (pair_rdata) begin
               pair_port.wr_en   = 1'b1;
               pair_port.wr_addr = bpa_pkg::pair_of(region_ff, lv_ff, loc_ff);
               pair_port.wr_data = 1'b0;
               n_in     = bpa_pkg::node_of(region_ff, lv_ff, loc_ff);
               state_in = ST_PUSH1;
            end else begin
               // unlink the free buddy, then merge one level up
               if (bpa_pkg::is_node(prev_rdata)) begin
                  next_port.wr_en   = 1'b1;
                  next_port.wr_addr = prev_rdata[NODE_W-1:0];
                  next_port.wr_data = x_code;
               end else if (prev_rdata[NODE_W-1:0] <= NODE_W'(ML)) begin
                  head_we  = 1'b1;
                  head_idx = prev_rdata[LVL_W-1:0];
                  head_wd  = x_code;
               end
               if (bpa_pkg::is_node(x_code)) begin
                  prev_port.wr_en   = 1'b1;
                  prev_port.wr_addr = x_code[NODE_W-1:0];
                  prev_port.wr_data = prev_rdata;
               end
               loc_in = loc_ff >> 1;
               lv_in  = lv_ff - LVL_W'(1);
               if (lv_ff == LVL_W'(1)) begin
                  n_in     = bpa_pkg::node_of(region_ff, '0, '0);
                  state_in = ST_PUSH1;
               end else begin
                  state_in = ST_F_RD;
               end
            end
         end
         ST_PUSH1: begin
            next_port.wr_en   = 1'b1;
            next_port.wr_addr = n_ff;
            next_port.wr_data = heads_ff[lv_ff];
            prev_port.wr_en   = 1'b1;
            prev_port.wr_addr = n_ff;
            prev_port.wr_data = bpa_pkg::head_ref(lv_ff);
            h_in     = heads_ff[lv_ff];
            head_we  = 1'b1;
            head_idx = lv_ff;
            head_wd  = {1'b0, n_ff};
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            if (bpa_pkg::is_node(h_ff)) begin
               prev_port.wr_en   = 1'b1;
               prev_port.wr_addr = h_ff[NODE_W-1:0];
               prev_port.wr_data = {1'b0, n_ff};
            end
            state_in = (func_ff == bpa_pkg::FUNC_ALLOC) ? ST_A_SPL : ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         cnt_ff   <= '0;
         for (int i = 0; i <= ML; i++) begin
            heads_ff[i] <= bpa_pkg::NIL;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (head_we) begin
            heads_ff[head_idx] <= head_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      lvl_ff    <= lvl_in;
      lv_ff     <= lv_in;
      loc_ff    <= loc_in;
      region_ff <= region_in;
      n_ff      <= n_in;
      h_ff      <= h_in;
      oom_ff    <= oom_in;
   end

endmodule

/* hw/rtl/buddy_page_allocator.sv */
// Alloc pops a free list and pushes one buddy per split level; free merges up
// through each level walked, then does a final push; the result then passes the
// output register. A failed alloc or an ignored free goes straight to the result.
// One transaction at a time: the next request is taken in the cycle the result
// appears. After reset a pass sets every pair bit with req_ready low; free lists
// start empty, links uninitialized.
module buddy_page_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [bpa_pkg::LVL_W-1:0] req_size_level,
   input  logic [bpa_pkg::IDX_W-1:0] req_block_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bpa_pkg::IDX_W-1:0] rsp_alloc_index,
   output logic                      rsp_out_of_memory
);

   bpa_pkg::pair_port_type pair_port;
   bpa_pkg::link_port_type next_port;
   bpa_pkg::link_port_type prev_port;
   bpa_pkg::result_type    res;
   logic                          res_valid;
   logic                          res_ready;
   logic                          pair_rdata;
   logic [bpa_pkg::CODE_W-1:0]    next_rdata;
   logic [bpa_pkg::CODE_W-1:0]    prev_rdata;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::IDX_W-1:0]     rsp_index_ff;
   logic                          rsp_oom_ff;

   bpa_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_size_level  (req_size_level),
      .req_block_index (req_block_index),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res),
      .pair_port       (pair_port),
      .next_port       (next_port),
      .prev_port       (prev_port),
      .pair_rdata      (pair_rdata),
      .next_rdata      (next_rdata),
      .prev_rdata      (prev_rdata)
   );

   bpa_ram #(.WIDTH(1), .ADDR_W(bpa_pkg::NODE_W)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_port.wr_en),
      .wr_addr (pair_port.wr_addr),
      .wr_data (pair_port.wr_data),
      .rd_en   (pair_port.rd_en),
      .rd_addr (pair_port.rd_addr),
      .rd_data (pair_rdata)
   );

   bpa_ram #(.WIDTH(bpa_pkg::CODE_W), .ADDR_W(bpa_pkg::NODE_W)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_port.wr_en),
      .wr_addr (next_port.wr_addr),
      .wr_data (next_port.wr_data),
      .rd_en   (next_port.rd_en),
      .rd_addr (next_port.rd_addr),
      .rd_data (next_rdata)
   );

   bpa_ram #(.WIDTH(bpa_pkg::CODE_W), .ADDR_W(bpa_pkg::NODE_W)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_port.wr_en),
      .wr_addr (prev_port.wr_addr),
      .wr_data (prev_port.wr_data),
      .rd_en   (prev_port.rd_en),
      .rd_addr (prev_port.rd_addr),
      .rd_data (prev_rdata)
   );

   // output register: the core hands off as soon as the slot frees up
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_index_ff <= res.alloc_index;
         rsp_oom_ff   <= res.out_of_memory;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_index   = rsp_index_ff;
   assign rsp_out_of_memory = rsp_oom_ff;

   a_oom_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_memory |-> rsp_alloc_index == '0)
      else $error("failed alloc carries a nonzero index");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer took a second transaction while busy");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input accepted before the pair clearing pass");

   a_core_handoff: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid)
      else $error("core dropped a result that was not taken");

endmodule
